// ===== rtl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// Types, constants and codes shared by the box collision table modules.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int MAX_BOXES = 32;
	localparam int ADDR_W    = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);

	localparam int POS_W     = 16;
	localparam int SIZE_W    = 15;
	localparam int TYPE_W    = 3;
	localparam int IDX_W     = 5;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int NUM_TYPES = 5;
	localparam int MASK_W    = NUM_TYPES * NUM_TYPES;
	localparam int MSEL_W    = $clog2(MASK_W);

	localparam int IN_W      = 112;
	localparam int OUT_W     = 16;
	localparam int CFG_W     = MASK_W;

	localparam logic [MASK_W-1:0] SKIP_MASK_RST = MASK_W'(13452548);
	localparam logic [TYPE_W-1:0] INVERT_RST    = TYPE_W'(4);

	localparam logic CFG_SKIP_MASK = 1'b0;
	localparam logic CFG_INVERT    = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_MOVE  = 3'd1,
		CMD_SET   = 3'd2,
		CMD_QUERY = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_UNUSED = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MOVE  = 5'b00010,
		S_QSELF = 5'b00100,
		S_QWALK = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} pos_t;

	typedef struct packed {
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [TYPE_W-1:0] kind;
	} attr_t;

	typedef struct packed {
		logic tested;
		logic hit;
	} ovl_t;

endpackage

// ===== rtl/aabb_collision_table_top.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_table_top
// Box table with add, move, set center, query and highlight read commands.
// A command goes from S_IDLE to S_DONE, by way of S_MOVE for a move and of S_QSELF
// and S_QWALK for a query, which reads one stored box per cycle from the box RAM.
// Next command is taken the cycle after the result is loaded into the output
// register. Reset loads the config defaults and clears entry count, highlights and
// the channels; box RAM contents are undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module aabb_collision_table_top import aabb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// cmd, entry_index, center_x, center_y, box_width, box_height, box_type,
	// delta_x, delta_y
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status, collided, hit_index, highlighted
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CMP_W = CNT_W + IDX_W;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [MAX_BOXES-1:0] hl_q;
	logic [MASK_W-1:0]   skip_mask_q;
	logic [TYPE_W-1:0]   invert_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	logic [ADDR_W-1:0]   cur_q, j_q;
	logic signed [POS_W-1:0] dx_q, dy_q;
	pos_t                self_pos_q;
	attr_t               self_attr_q;
	status_t             res_status_q;
	logic                res_coll_q;
	logic [IDX_W-1:0]    res_hit_q;
	logic                res_hl_q;

	logic [CMD_W-1:0]    in_cmd;
	logic [IDX_W-1:0]    in_idx;
	pos_t                in_pos;
	attr_t               in_attr;
	logic signed [POS_W-1:0] in_dx, in_dy;

	logic                in_fire, idx_ok, full, slot_free, last, j_self, hit_now;
	logic [ADDR_W-1:0]   in_addr;

	logic                pos_we, attr_we;
	logic [ADDR_W-1:0]   pos_waddr, raddr;
	pos_t                pos_wdata, pos_rdata;
	attr_t               attr_rdata;
	ovl_t                ovl;

	always_comb begin
		in_cmd    = s_axis_tdata[2:0];
		in_idx    = s_axis_tdata[7:3];
		in_pos.x  = s_axis_tdata[23:8];
		in_pos.y  = s_axis_tdata[39:24];
		in_attr.w = s_axis_tdata[54:40];
		in_attr.h = s_axis_tdata[69:55];
		in_attr.kind = s_axis_tdata[72:70];
		in_dx     = s_axis_tdata[88:73];
		in_dy     = s_axis_tdata[104:89];

		s_axis_tready = (state_q == S_IDLE);
		in_fire   = s_axis_tvalid && s_axis_tready;
		in_addr   = ADDR_W'(in_idx);
		idx_ok    = CMP_W'(in_idx) < CMP_W'(count_q);
		full      = count_q >= CNT_W'(MAX_BOXES);
		slot_free = !out_valid_q || m_axis_tready;
		last      = (CNT_W'(j_q) + CNT_W'(1)) >= count_q;
		j_self    = (j_q == cur_q);
		hit_now   = !j_self && ovl.hit;

		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = out_data_q;
	end

	// RAM port control
	always_comb begin
		pos_we    = 1'b0;
		attr_we   = 1'b0;
		pos_waddr = in_addr;
		pos_wdata = in_pos;
		case (state_q)
			S_QSELF: raddr = '0;
			S_QWALK: raddr = j_q + ADDR_W'(1);
			default: raddr = in_addr;
		endcase
		if (state_q == S_MOVE) begin
			pos_we      = 1'b1;
			pos_waddr   = cur_q;
			pos_wdata.x = pos_rdata.x + dx_q;
			pos_wdata.y = pos_rdata.y + dy_q;
		end else if (in_fire) begin
			case (cmd_t'(in_cmd))
				CMD_ADD: begin
					pos_waddr = ADDR_W'(count_q);
					pos_we    = !full;
					attr_we   = !full;
				end
				CMD_SET: pos_we = idx_ok;
				default: pos_we = 1'b0;
			endcase
		end
	end

	aabb_ram #(.WIDTH($bits(pos_t)), .DEPTH(MAX_BOXES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (raddr),
		.rdata (pos_rdata)
	);

	aabb_ram #(.WIDTH($bits(attr_t)), .DEPTH(MAX_BOXES)) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (ADDR_W'(count_q)),
		.wdata (in_attr),
		.raddr (raddr),
		.rdata (attr_rdata)
	);

	aabb_overlap u_overlap (
		.self_pos    (self_pos_q),
		.self_attr   (self_attr_q),
		.other_pos   (pos_rdata),
		.other_attr  (attr_rdata),
		.skip_mask   (skip_mask_q),
		.invert_code (invert_q),
		.result      (ovl)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hl_q        <= '0;
			skip_mask_q <= SKIP_MASK_RST;
			invert_q    <= INVERT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SKIP_MASK: skip_mask_q <= cfg_wdata;
					CFG_INVERT:    invert_q    <= cfg_wdata[TYPE_W-1:0];
					default:       invert_q    <= invert_q;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DONE;
						case (cmd_t'(in_cmd))
							CMD_ADD: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
									hl_q[ADDR_W'(count_q)] <= 1'b0;
								end
							end
							CMD_MOVE:  if (idx_ok) state_q <= S_MOVE;
							CMD_QUERY: if (idx_ok) state_q <= S_QSELF;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_MOVE:  state_q <= S_DONE;
				S_QSELF: state_q <= S_QWALK;
				S_QWALK: begin
					if (hit_now) begin
						hl_q[cur_q] <= 1'b1;
						hl_q[j_q]   <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						if (!j_self && ovl.tested) begin
							hl_q[j_q] <= 1'b0;
						end
						if (last) begin
							hl_q[cur_q] <= 1'b0;
							state_q     <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cur_q        <= in_addr;
					dx_q         <= in_dx;
					dy_q         <= in_dy;
					res_status_q <= ST_DONE;
					res_coll_q   <= 1'b0;
					res_hit_q    <= '0;
					res_hl_q     <= 1'b0;
					case (cmd_t'(in_cmd))
						CMD_ADD: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_hit_q <= IDX_W'(count_q);
							end
						end
						CMD_MOVE, CMD_SET, CMD_QUERY, CMD_READ: begin
							if (idx_ok) begin
								res_hl_q <= hl_q[in_addr];
							end else begin
								res_status_q <= ST_UNUSED;
							end
						end
						default: res_status_q <= ST_DONE;
					endcase
				end
			end
			S_QSELF: begin
				self_pos_q  <= pos_rdata;
				self_attr_q <= attr_rdata;
				j_q         <= '0;
			end
			S_QWALK: begin
				j_q <= j_q + ADDR_W'(1);
				if (hit_now) begin
					res_coll_q <= 1'b1;
					res_hit_q  <= IDX_W'(j_q);
					res_hl_q   <= 1'b1;
				end else if (last) begin
					res_hl_q <= 1'b0;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_data_q <= {(OUT_W-9)'(0), res_hl_q, res_hit_q, res_coll_q, res_status_q};
				end
			end
			default: j_q <= j_q;
		endcase
	end

endmodule

// ===== rtl/aabb_ram.sv =====
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aabb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/aabb_overlap.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap
// Pair filter and overlap test of the querying box against one other box.
// ----------------------------------------------------------------------------
module aabb_overlap import aabb_pkg::*; (
	input  pos_t              self_pos,
	input  attr_t             self_attr,
	input  pos_t              other_pos,
	input  attr_t             other_attr,
	input  logic [MASK_W-1:0] skip_mask,
	input  logic [TYPE_W-1:0] invert_code,
	output ovl_t              result
);

	logic signed [POS_W:0] dx, dy;
	logic [POS_W:0]        adx, ady;
	logic [SIZE_W:0]       wsum, hsum;
	logic                  overlap;
	logic                  skipped;
	logic [MSEL_W-1:0]     msel;

	always_comb begin
		dx   = (POS_W+1)'(self_pos.x) - (POS_W+1)'(other_pos.x);
		dy   = (POS_W+1)'(self_pos.y) - (POS_W+1)'(other_pos.y);
		adx  = dx[POS_W] ? $unsigned(-dx) : $unsigned(dx);
		ady  = dy[POS_W] ? $unsigned(-dy) : $unsigned(dy);
		wsum = (SIZE_W+1)'(self_attr.w) + (SIZE_W+1)'(other_attr.w);
		hsum = (SIZE_W+1)'(self_attr.h) + (SIZE_W+1)'(other_attr.h);
		overlap = ({adx, 1'b0} <= (POS_W+2)'(wsum)) && ({ady, 1'b0} <= (POS_W+2)'(hsum));

		msel = MSEL_W'(other_attr.kind) * MSEL_W'(NUM_TYPES) + MSEL_W'(self_attr.kind);
		if (other_attr.kind > TYPE_W'(NUM_TYPES - 1) || self_attr.kind > TYPE_W'(NUM_TYPES - 1)) begin
			skipped = 1'b0;
		end else begin
			skipped = skip_mask[msel];
		end

		result.tested = !skipped;
		result.hit    = !skipped && (overlap ^ (other_attr.kind == invert_code));
	end

endmodule

// ===== tb/aabb_table_checker.sv =====
// ----------------------------------------------------------------------------
// aabb_table_checker
// Watches the command, result and register ports of the box collision table.
// Keeps its own copy of the table and registers, works out the response to
// each accepted command and compares every returned result field by field.
// ----------------------------------------------------------------------------
module aabb_table_checker import aabb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IN_W-106:0]       pad;
		logic signed [POS_W-1:0] dy;
		logic signed [POS_W-1:0] dx;
		logic [TYPE_W-1:0]       kind;
		logic [SIZE_W-1:0]       h;
		logic [SIZE_W-1:0]       w;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cx;
		logic [IDX_W-1:0]        idx;
		logic [CMD_W-1:0]        cmd;
	} box_cmd_t;

	typedef struct packed {
		logic [OUT_W-10:0]   pad;
		logic                highlighted;
		logic [IDX_W-1:0]    hit_index;
		logic                collided;
		logic [STATUS_W-1:0] status;
	} box_result_t;

	logic [MASK_W-1:0]       skip_mask;
	logic [TYPE_W-1:0]       invert_kind;
	logic signed [POS_W-1:0] box_x [MAX_BOXES];
	logic signed [POS_W-1:0] box_y [MAX_BOXES];
	logic [SIZE_W-1:0]       box_w [MAX_BOXES];
	logic [SIZE_W-1:0]       box_h [MAX_BOXES];
	logic [TYPE_W-1:0]       box_kind [MAX_BOXES];
	logic                    box_lit [MAX_BOXES];
	int                      box_count;
	box_result_t             expected_results [$];
	box_result_t             got, want;
	int                      k;

	task automatic report_mismatch(string what, int got_val, int want_val);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got_val, want_val);
		mismatches++;
	endtask

	// types beyond the named five never consult the mask
	function automatic logic pair_skipped(logic [TYPE_W-1:0] other_kind,
			logic [TYPE_W-1:0] own_kind);
		if (other_kind >= NUM_TYPES || own_kind >= NUM_TYPES)
			return 1'b0;
		return skip_mask[int'(other_kind) * NUM_TYPES + int'(own_kind)];
	endfunction

	function automatic logic boxes_touch(int a, int b);
		int ddx, ddy;
		ddx = int'(box_x[a]) - int'(box_x[b]);
		ddy = int'(box_y[a]) - int'(box_y[b]);
		if (ddx < 0) ddx = -ddx;
		if (ddy < 0) ddy = -ddy;
		return (2 * ddx <= int'(box_w[a]) + int'(box_w[b])) &&
			(2 * ddy <= int'(box_h[a]) + int'(box_h[b]));
	endfunction

	function automatic box_result_t apply_command(box_cmd_t c);
		box_result_t r;
		int          i, j;
		logic        found, ovl;
		r = '0;
		i = int'(c.idx);
		if (c.cmd == CMD_ADD) begin
			if (box_count >= MAX_BOXES) begin
				r.status = ST_FULL;
			end else begin
				box_x[box_count]    = c.cx;
				box_y[box_count]    = c.cy;
				box_w[box_count]    = c.w;
				box_h[box_count]    = c.h;
				box_kind[box_count] = c.kind;
				box_lit[box_count]  = 1'b0;
				r.hit_index         = box_count[IDX_W-1:0];
				box_count++;
			end
		end else if (c.cmd <= CMD_READ) begin
			if (i >= box_count) begin
				r.status = ST_UNUSED;
			end else begin
				case (c.cmd)
					CMD_MOVE: begin
						box_x[i] = box_x[i] + c.dx;
						box_y[i] = box_y[i] + c.dy;
					end
					CMD_SET: begin
						box_x[i] = c.cx;
						box_y[i] = c.cy;
					end
					CMD_QUERY: begin
						found = 1'b0;
						for (j = 0; j < box_count && !found; j++) begin
							if (j != i && !pair_skipped(box_kind[j], box_kind[i])) begin
								ovl = boxes_touch(i, j);
								if (box_kind[j] == invert_kind)
									ovl = !ovl;
								if (ovl) begin
									box_lit[i]  = 1'b1;
									box_lit[j]  = 1'b1;
									found       = 1'b1;
									r.collided  = 1'b1;
									r.hit_index = j[IDX_W-1:0];
								end else begin
									box_lit[j] = 1'b0;
								end
							end
						end
						if (!found)
							box_lit[i] = 1'b0;
					end
					default: ;
				endcase
				r.highlighted = box_lit[i];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_mask   = SKIP_MASK_RST;
			invert_kind = INVERT_RST;
			box_count   = 0;
			for (k = 0; k < MAX_BOXES; k++)
				box_lit[k] = 1'b0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SKIP_MASK)
					skip_mask = cfg_wdata;
				else
					invert_kind = cfg_wdata[TYPE_W-1:0];
			end
			if (s_tvalid && s_tready)
				expected_results.insert(expected_results.size(),
					apply_command(box_cmd_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = box_result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", int'(m_tdata), 0);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.collided != want.collided)
						report_mismatch("collided", got.collided, want.collided);
					if (got.hit_index != want.hit_index)
						report_mismatch("hit_index", got.hit_index, want.hit_index);
					if (got.highlighted != want.highlighted)
						report_mismatch("highlighted", got.highlighted, want.highlighted);
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== tb/tb_aabb_collision_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_collision_table_top
// Drives the box collision table with directed corner cases and then phases
// of random commands under several register settings, with random gaps and
// output stalls; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aabb_collision_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int NUM_PHASES       = 6;
	localparam int RANDOM_PER_PHASE = 105;
	localparam int DRAIN_CYCLES     = 48;

	localparam int TYPE_NONE     = 0;
	localparam int TYPE_PLAYER   = 1;
	localparam int TYPE_ENEMY    = 2;
	localparam int TYPE_BULLET   = 3;
	localparam int TYPE_INVERTED = 4;
	localparam int TYPE_SPARE    = 7;

	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_READ + 1'b1;

	typedef struct packed {
		logic [IN_W-106:0]       pad;
		logic signed [POS_W-1:0] dy;
		logic signed [POS_W-1:0] dx;
		logic [TYPE_W-1:0]       kind;
		logic [SIZE_W-1:0]       h;
		logic [SIZE_W-1:0]       w;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cx;
		logic [IDX_W-1:0]        idx;
		logic [CMD_W-1:0]        cmd;
	} box_cmd_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic             free_run = 1'b0;
	int               mismatches;
	int               outstanding;
	int               n_added;
	int               cycle_count = 0;

	aabb_collision_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	aabb_table_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= free_run || ($urandom_range(0, 99) >= 11);
	end

	function automatic box_cmd_t make_cmd(logic [CMD_W-1:0] op, int idx, int cx, int cy,
			int w, int h, int kind, int dx, int dy);
		box_cmd_t c;
		c      = '0;
		c.cmd  = op;
		c.idx  = IDX_W'(idx);
		c.cx   = POS_W'(cx);
		c.cy   = POS_W'(cy);
		c.w    = SIZE_W'(w);
		c.h    = SIZE_W'(h);
		c.kind = TYPE_W'(kind);
		c.dx   = POS_W'(dx);
		c.dy   = POS_W'(dy);
		return c;
	endfunction

	function automatic logic [POS_W-1:0] near_zero(int span);
		int v;
		v = $urandom_range(0, 2 * span);
		v = v - span;
		return v[POS_W-1:0];
	endfunction

	// mostly clustered boxes on live entries so queries find hits
	function automatic box_cmd_t random_command();
		box_cmd_t     c;
		logic [127:0] noise;
		int           r;
		noise = {$urandom(), $urandom(), $urandom(), $urandom()};
		c     = noise[IN_W-1:0];
		c.pad = '0;
		r     = $urandom_range(0, 99);
		if (r < 3)
			c.cmd = CMD_W'($urandom_range(int'(CMD_FIRST_UNUSED), 2**CMD_W - 1));
		else if (r < 25)
			c.cmd = CMD_ADD;
		else if (r < 37)
			c.cmd = CMD_MOVE;
		else if (r < 47)
			c.cmd = CMD_SET;
		else if (r < 80)
			c.cmd = CMD_QUERY;
		else
			c.cmd = CMD_READ;
		if (n_added > 0 && $urandom_range(0, 99) < 88)
			c.idx = IDX_W'($urandom_range(0, n_added - 1));
		if ($urandom_range(0, 99) < 85) begin
			c.cx = near_zero(600);
			c.cy = near_zero(600);
			c.dx = near_zero(40);
			c.dy = near_zero(40);
			c.w  = SIZE_W'($urandom_range(0, 500));
			c.h  = SIZE_W'($urandom_range(0, 500));
		end
		if ($urandom_range(0, 99) < 90)
			c.kind = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
		return c;
	endfunction

	task automatic send_item(input box_cmd_t item);
		while (!free_run && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= item;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (item.cmd == CMD_ADD && n_added < MAX_BOXES)
			n_added++;
	endtask

	task automatic settle(input int extra);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
		cfg_index <= sel;
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int p, k;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SKIP_MASK;
		cfg_wdata     = '0;
		n_added       = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, unknown commands
		send_item(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_READ, 31, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_MOVE, 0, 0, 0, 0, 0, TYPE_NONE, 5, 5));
		send_item(make_cmd(CMD_SET, 0, 1, 1, 0, 0, TYPE_NONE, 0, 0));
		for (k = 0; k < 3; k++)
			send_item(make_cmd(CMD_W'(int'(CMD_FIRST_UNUSED) + k), 0, 0, 0, 0, 0,
				TYPE_NONE, 0, 0));
		// boxes at the field extremes
		send_item(make_cmd(CMD_ADD, 0, 0, 0, 10, 10, TYPE_PLAYER, 0, 0));
		send_item(make_cmd(CMD_ADD, 0, 32767, -32768, 32767, 32767, TYPE_ENEMY, 0, 0));
		send_item(make_cmd(CMD_ADD, 0, -32768, 32767, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_ADD, 0, 5, 5, 4, 4, TYPE_INVERTED, 0, 0));
		send_item(make_cmd(CMD_ADD, 0, 3, 0, 0, 0, TYPE_SPARE, 0, 0));
		send_item(make_cmd(CMD_ADD, 0, 0, 0, 6, 6, TYPE_BULLET, 0, 0));
		send_item(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_QUERY, 4, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_QUERY, 3, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		// position wrap on move
		send_item(make_cmd(CMD_MOVE, 1, 0, 0, 0, 0, TYPE_NONE, 1, 1));
		send_item(make_cmd(CMD_MOVE, 2, 0, 0, 0, 0, TYPE_NONE, -32768, -32768));
		send_item(make_cmd(CMD_MOVE, 0, 0, 0, 0, 0, TYPE_NONE, 32767, 32767));
		send_item(make_cmd(CMD_SET, 3, -32768, 32767, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_READ, 3, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_QUERY, 1, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_QUERY, 5, 0, 0, 0, 0, TYPE_NONE, 0, 0));
		send_item(make_cmd(CMD_READ, 6, 0, 0, 0, 0, TYPE_NONE, 0, 0));

		for (p = 0; p < NUM_PHASES; p++) begin
			settle(4);
			case (p)
				0: begin
					write_reg(CFG_SKIP_MASK, '0);
					write_reg(CFG_INVERT, CFG_W'(TYPE_NONE));
				end
				1: begin
					write_reg(CFG_SKIP_MASK, '1);
					write_reg(CFG_INVERT, CFG_W'(TYPE_INVERTED));
				end
				2: begin
					write_reg(CFG_SKIP_MASK, CFG_W'($urandom()));
					write_reg(CFG_INVERT, CFG_W'($urandom_range(0, NUM_TYPES - 1)));
				end
				3: begin
					write_reg(CFG_SKIP_MASK, SKIP_MASK_RST);
					write_reg(CFG_INVERT, CFG_W'(INVERT_RST));
				end
				4: begin
					write_reg(CFG_SKIP_MASK, CFG_W'($urandom()));
					write_reg(CFG_INVERT, CFG_W'(TYPE_ENEMY));
				end
				default: begin
					write_reg(CFG_SKIP_MASK, '0);
					write_reg(CFG_INVERT, CFG_W'(TYPE_INVERTED));
				end
			endcase
			free_run <= (p == 2);
			for (k = 0; k < RANDOM_PER_PHASE; k++)
				send_item(random_command());
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
